// ----- design/cse_pkg.sv -----
// cse_pkg: widths, constants and the stage record of the chebyshev series evaluator
// no dependencies; used by chebyshev_series_eval
`timescale 1ns / 1ps

package cse_pkg;

    localparam int MAX_ORDER_DEF = 7;   // default order of the series
    localparam int NUM_COEF      = 7;   // number of coefficient registers
    localparam int CFG_IW        = 3;   // register index width

    localparam int X_W   = 17;  // abscissa, Q2.15
    localparam int C_W   = 16;  // coefficient, Q4.12
    localparam int T_W   = 33;  // polynomial value, Q.30 with headroom
    localparam int P_W   = X_W + T_W;   // x * T product, Q.45
    localparam int M_W   = C_W + T_W;   // coef * T product, Q.42
    localparam int A_W   = 52;  // accumulator, Q.42
    localparam int D_W   = 24;  // density, Q8.16
    localparam int OSH   = 26;  // Q.42 -> Q.16
    localparam int Q_W   = A_W - OSH;

    localparam logic signed [X_W-1:0] X_ONE  = 17'sd32768;
    localparam logic signed [X_W-1:0] X_MONE = -17'sd32768;
    localparam logic signed [T_W-1:0] T_ONE  = 33'sd1073741824;
    localparam logic signed [A_W-1:0] A_ONE  = 52'sd4398046511104;
    // half lsb for the recurrence rounding: 2*x*T >> 15 is x*T >> 14
    localparam logic signed [P_W-1:0] P_RND  = 50'sd8192;
    localparam logic signed [A_W-1:0] A_RND  = 52'sd33554432;
    localparam logic signed [Q_W-1:0] Q_MAX  = 26'sd8388607;
    localparam logic signed [Q_W-1:0] Q_MIN  = -26'sd8388608;

    // record carried through every pipeline stage but the final rounding stage
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [T_W-1:0] tprev;
        logic signed [T_W-1:0] tcur;
        logic signed [A_W-1:0] acc;
        logic signed [P_W-1:0] p;
        logic signed [M_W-1:0] m;
    } t_stage;

endpackage

// ----- design/chebyshev_series_eval.sv -----
// chebyshev_series_eval: pipelined evaluation of 1 + sum c_n*T_n(x), n = 1..MAX_ORDER
// depends on cse_pkg (widths, rounding constants, stage record)
`timescale 1ns / 1ps

// usage
// - input channel: i_in_valid / o_in_stall carry one abscissa i_pos (signed Q2.15);
//   values outside [-1,1] are clamped to the nearest end
// - output channel: o_out_valid / i_out_stall carry o_density (signed Q8.16)
// - configuration: i_cfg_valid / o_cfg_ready with i_cfg_index 0..6 for coef_1..coef_7
//   (signed Q4.12); ready is always high, index 7 is ignored; write only while idle
// - throughput: one request per cycle while no stall holds the pipeline; each
//   order has a multiply stage (x*T_n and c_n*T_n side by side) and an add stage
//   (recurrence and accumulate)
// - stall: each stage holds while it is full and the stage after it is held, so
//   bubbles close up and new requests still enter until every stage is full
// - reset: synchronous, active low; empties the pipeline and clears the coefficients

module chebyshev_series_eval #(
    parameter int MAX_ORDER = cse_pkg::MAX_ORDER_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [cse_pkg::X_W-1:0]  i_pos,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [cse_pkg::D_W-1:0]  o_density,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cse_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic signed [cse_pkg::C_W-1:0]  i_cfg_data
);

    // stage 0 clamps, stages 2n-1 / 2n handle order n, the last stage rounds
    localparam int NS = 2 * MAX_ORDER + 2;

    logic signed [cse_pkg::C_W-1:0] r_coef [cse_pkg::NUM_COEF];
    cse_pkg::t_stage                r_st   [NS-1];
    cse_pkg::t_stage                n_st   [NS-1];
    logic [NS-1:0]                  r_v;
    logic [NS:0]                    adv;    // stage may load this cycle
    logic signed [cse_pkg::D_W-1:0] r_density;
    logic signed [cse_pkg::D_W-1:0] n_density;

    // coefficient registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cse_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int i = 0; i < cse_pkg::NUM_COEF; i++) begin
                if (i_cfg_index == cse_pkg::CFG_IW'(i)) begin
                    r_coef[i] <= i_cfg_data;
                end
            end
        end
    end

    // flow control: a stage loads when empty or when its successor loads
    assign adv[NS] = !i_out_stall;
    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_adv
            assign adv[s] = !r_v[s] || adv[s+1];
        end
    endgenerate

    assign o_in_stall  = !adv[0];
    assign o_out_valid = r_v[NS-1];
    assign o_density   = r_density;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage datapath
    generate
        for (s = 0; s < NS - 1; s++) begin : g_stage
            if (s == 0) begin : g_in
                // clamp to [-1,1], T_0 = 1, T_1 = x
                always_comb begin
                    n_st[s]       = '0;
                    n_st[s].x     = i_pos;
                    if (i_pos > cse_pkg::X_ONE) begin
                        n_st[s].x = cse_pkg::X_ONE;
                    end
                    if (i_pos < cse_pkg::X_MONE) begin
                        n_st[s].x = cse_pkg::X_MONE;
                    end
                    n_st[s].tprev = cse_pkg::T_ONE;
                    n_st[s].tcur  = cse_pkg::T_W'(n_st[s].x) <<< 15;
                    n_st[s].acc   = cse_pkg::A_ONE;
                end
            end else if (s % 2 == 1) begin : g_mul
                // both products of order (s+1)/2 in parallel
                always_comb begin
                    n_st[s]   = r_st[s-1];
                    n_st[s].p = r_st[s-1].x * r_st[s-1].tcur;
                    n_st[s].m = r_coef[(s-1)/2] * r_st[s-1].tcur;
                end
            end else begin : g_add
                logic signed [cse_pkg::P_W-1:0] v_psum;
                always_comb begin
                    v_psum        = r_st[s-1].p + cse_pkg::P_RND;
                    n_st[s]       = r_st[s-1];
                    n_st[s].tprev = r_st[s-1].tcur;
                    n_st[s].tcur  = $signed(v_psum[cse_pkg::T_W+13:14]) - r_st[s-1].tprev;
                    n_st[s].acc   = r_st[s-1].acc + cse_pkg::A_W'(r_st[s-1].m);
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv[s]) begin
                    r_st[s] <= n_st[s];
                end
            end
        end
    endgenerate

    // final rounding to Q8.16 with saturation
    logic signed [cse_pkg::A_W-1:0] v_acc;
    logic signed [cse_pkg::Q_W-1:0] v_q;

    always_comb begin
        v_acc = r_st[NS-2].acc + cse_pkg::A_RND;
        v_q   = $signed(v_acc[cse_pkg::A_W-1:cse_pkg::OSH]);
        if (v_q > cse_pkg::Q_MAX) begin
            n_density = cse_pkg::D_W'(cse_pkg::Q_MAX);
        end else if (v_q < cse_pkg::Q_MIN) begin
            n_density = cse_pkg::D_W'(cse_pkg::Q_MIN);
        end else begin
            n_density = v_q[cse_pkg::D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_density <= n_density;
        end
    end

    // checks
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v))
        else $error("input held while a stage is empty");

    a_flow_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && r_v[NS-2]) |=> o_out_valid)
        else $error("item lost between last two stages");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result shown straight after reset");

    a_no_stall_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input held while output drains");

endmodule
